### rtl/core/bsrs_pkg.sv
// Shared types and codes for the bounded set with rank select.
package bsrs_pkg;

    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned RANK_BITS  = 4;
    localparam int unsigned COUNT_BITS = 5;
    localparam int unsigned LIMIT_BITS = 5;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_ERASE    = 2'd1,
        ACT_CONTAINS = 2'd2,
        ACT_GET      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_INSERT,
        UPD_ERASE
    } t_upd;

    typedef struct packed {
        logic cmp_en;
        t_upd upd;
    } t_cell_ctl;

    typedef struct packed {
        t_action               action;
        logic [KEY_BITS-1:0]   key;
        logic [RANK_BITS-1:0]  rank_index;
    } t_in_word;

    typedef struct packed {
        logic                  ok;
        logic [KEY_BITS-1:0]   key_out;
        logic [COUNT_BITS-1:0] item_count;
    } t_out_word;

endpackage

### rtl/core/bsrs_cell.sv
// One cell of the sorted key chain: holds a key, compares, shifts.
module bsrs_cell #(
    parameter int unsigned KEY_WIDTH = 32
) (
    input  logic                  i_clk,
    input  bsrs_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_WIDTH-1:0]  i_key,
    input  logic                  i_valid,
    input  logic [KEY_WIDTH-1:0]  i_left_key,
    input  logic                  i_left_place,
    input  logic [KEY_WIDTH-1:0]  i_right_key,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic                  o_place,
    output logic                  o_eq
);

    logic [KEY_WIDTH-1:0] r_key;
    logic                 r_place;  // new key goes here or further left
    logic                 r_ge;     // held key at or above the probe
    logic                 r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_place <= !i_valid || (r_key > i_key);
            r_ge    <= i_valid && (r_key >= i_key);
            r_eq    <= i_valid && (r_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.upd)
            bsrs_pkg::UPD_INSERT: begin
                if (i_left_place) begin
                    r_key <= i_left_key;
                end else if (r_place) begin
                    r_key <= i_key;
                end
            end
            bsrs_pkg::UPD_ERASE: begin
                if (r_ge) begin
                    r_key <= i_right_key;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key   = r_key;
    assign o_place = r_place;
    assign o_eq    = r_eq;

endmodule

### rtl/core/bsrs_chain.sv
// Row of key cells kept in ascending order, neighbors linked both ways.
module bsrs_chain #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  bsrs_pkg::t_cell_ctl                  i_ctl,
    input  logic [KEY_WIDTH-1:0]                 i_key,
    input  logic [CAPACITY-1:0]                  i_valid,
    output logic [CAPACITY-1:0][KEY_WIDTH-1:0]   o_keys,
    output logic [CAPACITY-1:0]                  o_eq
);

    logic [CAPACITY-1:0] w_place;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_WIDTH-1:0] w_left_key;
        logic                 w_left_place;
        logic [KEY_WIDTH-1:0] w_right_key;

        if (g == 0) begin : g_first
            assign w_left_key   = i_key;
            assign w_left_place = 1'b0;
        end else begin : g_mid
            assign w_left_key   = o_keys[g-1];
            assign w_left_place = w_place[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = o_keys[g];
        end else begin : g_inner
            assign w_right_key = o_keys[g+1];
        end

        bsrs_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_key        (i_key),
            .i_valid      (i_valid[g]),
            .i_left_key   (w_left_key),
            .i_left_place (w_left_place),
            .i_right_key  (w_right_key),
            .o_key        (o_keys[g]),
            .o_place      (w_place[g]),
            .o_eq         (o_eq[g])
        );
    end

endmodule

### rtl/core/bounded_set_with_rank_select_unit.sv
// Top level: bounded ordered key set with insert, erase, lookup and rank select.
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_ready       i_data  (t_in_word)
//  result    out        o_valid / i_ready       o_data  (t_out_word)
//  config    in         i_cfg_we                i_cfg_data (capacity limit)
//
// Each word passes through the idle state that takes it, a compare state in
// which all cells compare the key in parallel, and an update state that
// shifts the chain and loads the result register.
// The control sequencer handles one word at a time.
// A finished result may wait in the output register while the next word is
// taken; the update cycle stalls only while that register is still full.
// Reset empties the set and restores the limit to 16; no clearing pass.
module bounded_set_with_rank_select_unit #(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  bsrs_pkg::t_in_word                        i_data,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output bsrs_pkg::t_out_word                       o_data,
    input  logic                                      i_cfg_we,
    input  logic [bsrs_pkg::LIMIT_BITS-1:0]           i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CW    = (CNT_W > bsrs_pkg::LIMIT_BITS) ?
                                    CNT_W : bsrs_pkg::LIMIT_BITS;

    bsrs_pkg::t_state    r_state, n_state;
    bsrs_pkg::t_action   r_act;
    logic [KEY_WIDTH-1:0] r_key, w_key_in;
    logic [bsrs_pkg::RANK_BITS-1:0] r_rank;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [bsrs_pkg::LIMIT_BITS-1:0] r_limit;
    logic                r_out_valid;
    bsrs_pkg::t_out_word r_out, n_out;
    logic                w_out_load;
    logic                w_accept;

    bsrs_pkg::t_cell_ctl w_ctl;
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0][KEY_WIDTH-1:0] w_keys;

    logic [CW-1:0]       w_count_ext;
    logic [CW-1:0]       w_limit_eff;
    logic                w_found;
    logic                w_ins_ok;
    logic                w_rank_ok;
    logic [KEY_WIDTH-1:0] w_rank_key;
    logic [bsrs_pkg::KEY_BITS-1:0] w_rank_key_out;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == bsrs_pkg::ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    if (KEY_WIDTH >= bsrs_pkg::KEY_BITS) begin : g_key_wide
        assign w_key_in       = KEY_WIDTH'(i_data.key);
        assign w_rank_key_out = w_rank_key[bsrs_pkg::KEY_BITS-1:0];
    end else begin : g_key_narrow
        assign w_key_in       = i_data.key[KEY_WIDTH-1:0];
        assign w_rank_key_out = bsrs_pkg::KEY_BITS'(w_rank_key);
    end

    assign w_count_ext = CW'(r_count);
    assign w_limit_eff = (CW'(r_limit) < CW'(CAPACITY)) ? CW'(r_limit) : CW'(CAPACITY);
    assign w_found     = |w_eq;
    assign w_ins_ok    = (w_count_ext < w_limit_eff) && !w_found;
    assign w_rank_ok   = CW'(r_rank) < w_count_ext;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i] = CW'(i) < w_count_ext;
        end
    end

    // chain is sorted and keys are distinct, so rank equals position
    always_comb begin
        w_rank_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(r_rank) == CW'(i)) begin
                w_rank_key = w_keys[i];
            end
        end
    end

    bsrs_chain #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_key   (r_key),
        .i_valid (w_valid),
        .o_keys  (w_keys),
        .o_eq    (w_eq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsrs_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        w_ctl      = '{cmp_en: 1'b0, upd: bsrs_pkg::UPD_NONE};
        w_out_load = 1'b0;
        n_out      = '0;
        n_out.item_count = bsrs_pkg::COUNT_BITS'(r_count);
        unique case (r_state)
            bsrs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = bsrs_pkg::ST_CMP;
                end
            end
            bsrs_pkg::ST_CMP: begin
                w_ctl.cmp_en = 1'b1;
                n_state      = bsrs_pkg::ST_UPD;
            end
            bsrs_pkg::ST_UPD: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = bsrs_pkg::ST_IDLE;
                    unique case (r_act)
                        bsrs_pkg::ACT_INSERT: begin
                            if (w_ins_ok) begin
                                w_ctl.upd = bsrs_pkg::UPD_INSERT;
                                n_count   = r_count + 1'b1;
                                n_out.ok  = 1'b1;
                            end
                        end
                        bsrs_pkg::ACT_ERASE: begin
                            if (w_found) begin
                                w_ctl.upd = bsrs_pkg::UPD_ERASE;
                                n_count   = r_count - 1'b1;
                                n_out.ok  = 1'b1;
                            end
                        end
                        bsrs_pkg::ACT_CONTAINS: begin
                            n_out.ok = w_found;
                        end
                        bsrs_pkg::ACT_GET: begin
                            if (w_rank_ok) begin
                                n_out.ok      = 1'b1;
                                n_out.key_out = w_rank_key_out;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.item_count = bsrs_pkg::COUNT_BITS'(n_count);
                end
            end
            default: begin
                n_state = bsrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act  <= i_data.action;
            r_key  <= w_key_in;
            r_rank <= i_data.rank_index;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bsrs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_count) <= CW'(CAPACITY))
        else $error("held count above capacity");

    a_eq_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsrs_pkg::ST_UPD) |-> $onehot0(w_eq))
        else $error("key matched in more than one cell");

    a_fail_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.ok) |-> (o_data.key_out == '0))
        else $error("failed result carries a key");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.upd == bsrs_pkg::UPD_INSERT) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not bump the count");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == bsrs_pkg::ST_CMP))
        else $error("accepted word did not start a compare");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded set with rank select unit.
module testbench;

    localparam int unsigned SET_DEPTH    = 16;
    localparam int unsigned MAX_WAIT     = 14;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned RANDOM_WORDS = 150;
    localparam int unsigned POOL_SIZE    = 24;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_ready;
    bsrs_pkg::t_in_word              i_data;
    logic                            o_valid;
    logic                            i_ready;
    bsrs_pkg::t_out_word             o_data;
    logic                            i_cfg_we;
    logic [bsrs_pkg::LIMIT_BITS-1:0] i_cfg_data;

    bounded_set_with_rank_select_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the set; order of entries does not matter
    logic [bsrs_pkg::KEY_BITS-1:0]   model_keys [SET_DEPTH];
    int unsigned                     model_count;
    logic [bsrs_pkg::LIMIT_BITS-1:0] model_limit;

    logic [bsrs_pkg::KEY_BITS-1:0]   key_pool [POOL_SIZE];
    bsrs_pkg::t_out_word             pending_results [$];
    bsrs_pkg::t_out_word             want_word;

    int unsigned fail_count;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned idle_cycles;
    int unsigned stall_left;
    int unsigned action_hits [4];
    bit          burst_mode;
    bit          hold_req;
    bit          hold_active;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bsrs_pkg::t_out_word set_op_result(bsrs_pkg::t_in_word w);
        bsrs_pkg::t_out_word r;
        int unsigned         eff_limit;
        int                  found_at;
        int unsigned         smaller;
        r = '0;
        found_at = -1;
        eff_limit = (model_limit > SET_DEPTH) ? SET_DEPTH : 32'(model_limit);
        for (int i = 0; i < model_count; i++)
            if (model_keys[i] == w.key) found_at = i;
        case (w.action)
            bsrs_pkg::ACT_INSERT: begin
                if (model_count < eff_limit && found_at < 0) begin
                    model_keys[model_count] = w.key;
                    model_count++;
                    r.ok = 1'b1;
                end
            end
            bsrs_pkg::ACT_ERASE: begin
                if (found_at >= 0) begin
                    for (int i = found_at; i + 1 < model_count; i++)
                        model_keys[i] = model_keys[i+1];
                    model_count--;
                    r.ok = 1'b1;
                end
            end
            bsrs_pkg::ACT_CONTAINS: begin
                r.ok = (found_at >= 0);
            end
            bsrs_pkg::ACT_GET: begin
                // key with exactly rank_index smaller keys
                if (w.rank_index < model_count) begin
                    for (int j = 0; j < model_count; j++) begin
                        smaller = 0;
                        for (int i = 0; i < model_count; i++)
                            if (model_keys[i] < model_keys[j]) smaller++;
                        if (smaller == w.rank_index && !r.ok) begin
                            r.key_out = model_keys[j];
                            r.ok = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.item_count = model_count[bsrs_pkg::COUNT_BITS-1:0];
        return r;
    endfunction

    function automatic bsrs_pkg::t_in_word make_word(bsrs_pkg::t_action a,
                                                     logic [bsrs_pkg::KEY_BITS-1:0] k,
                                                     logic [bsrs_pkg::RANK_BITS-1:0] rk);
        bsrs_pkg::t_in_word w;
        w.action = a;
        w.key = k;
        w.rank_index = rk;
        return w;
    endfunction

    function automatic bsrs_pkg::t_in_word random_word();
        int unsigned                    pick;
        bsrs_pkg::t_action              a;
        logic [bsrs_pkg::KEY_BITS-1:0]  k;
        logic [bsrs_pkg::RANK_BITS-1:0] rk;
        pick = $urandom_range(0, 99);
        if (pick < 35) a = bsrs_pkg::ACT_INSERT;
        else if (pick < 60) a = bsrs_pkg::ACT_ERASE;
        else if (pick < 80) a = bsrs_pkg::ACT_CONTAINS;
        else a = bsrs_pkg::ACT_GET;
        // mostly pool keys so erase and lookup hit stored entries
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else k = $urandom();
        if (a == bsrs_pkg::ACT_GET && model_count > 0 && $urandom_range(0, 99) < 80)
            rk = bsrs_pkg::RANK_BITS'($urandom_range(0, model_count - 1));
        else
            rk = bsrs_pkg::RANK_BITS'($urandom_range(0, 15));
        return make_word(a, k, rk);
    endfunction

    task automatic send_word(input bsrs_pkg::t_in_word w);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data = w;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(set_op_result(w));
        action_hits[w.action]++;
        words_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [bsrs_pkg::LIMIT_BITS-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        model_limit = value;
    endtask

    task automatic test_directed_basics();
        send_word(make_word(bsrs_pkg::ACT_GET, 32'h0000_0000, 4'd0));
        send_word(make_word(bsrs_pkg::ACT_ERASE, 32'h0000_0005, 4'd15));
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h0000_0000, 4'd7));
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'hFFFF_FFFF, 4'd8));
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h0000_0000, 4'd0));
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h8000_0000, 4'd3));
        send_word(make_word(bsrs_pkg::ACT_CONTAINS, 32'hFFFF_FFFF, 4'd12));
        send_word(make_word(bsrs_pkg::ACT_CONTAINS, 32'h0000_0005, 4'd0));
        send_word(make_word(bsrs_pkg::ACT_GET, 32'h5555_5555, 4'd0));
        send_word(make_word(bsrs_pkg::ACT_GET, 32'hAAAA_AAAA, 4'd1));
        send_word(make_word(bsrs_pkg::ACT_GET, 32'h0000_0000, 4'd2));
        send_word(make_word(bsrs_pkg::ACT_GET, 32'h0000_0000, 4'd3));
        send_word(make_word(bsrs_pkg::ACT_ERASE, 32'hFFFF_FFFF, 4'd5));
        send_word(make_word(bsrs_pkg::ACT_ERASE, 32'hFFFF_FFFF, 4'd10));
        send_word(make_word(bsrs_pkg::ACT_GET, 32'h0000_0000, 4'd15));
    endtask

    task automatic test_limit_edges();
        int unsigned tries;
        write_limit(5'd0);
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h0000_0007, 4'd9));
        // limit past the cell count: fills to 16 and then refuses
        write_limit(5'd31);
        tries = 0;
        while (model_count < SET_DEPTH && tries < 40) begin
            send_word(make_word(bsrs_pkg::ACT_INSERT, $urandom(),
                                bsrs_pkg::RANK_BITS'($urandom_range(0, 15))));
            tries++;
        end
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h1234_5678, 4'd0));
        send_word(make_word(bsrs_pkg::ACT_GET, 32'h0000_0000, 4'd15));
        // lowered below the count: stored keys stay, inserts refused
        write_limit(5'd1);
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h0000_0009, 4'd4));
        send_word(make_word(bsrs_pkg::ACT_ERASE, 32'h8000_0000, 4'd6));
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h0000_0009, 4'd2));
        send_word(make_word(bsrs_pkg::ACT_CONTAINS, 32'h0000_0000, 4'd11));
        write_limit(bsrs_pkg::LIMIT_RESET);
        send_word(make_word(bsrs_pkg::ACT_INSERT, 32'h0000_0009, 4'd1));
    endtask

    task automatic test_backpressure();
        drain();
        hold_req = 1'b1;
        burst_mode = 1'b1;
        repeat (24) send_word(random_word());
        burst_mode = 1'b0;
        drain();
    endtask

    task automatic test_random_mix();
        logic [bsrs_pkg::LIMIT_BITS-1:0] phase_limits [6];
        phase_limits = '{bsrs_pkg::LIMIT_RESET, 5'd5, 5'd31, 5'd1, 5'd16,
                         bsrs_pkg::LIMIT_RESET};
        phase_limits[4] = bsrs_pkg::LIMIT_BITS'($urandom_range(2, 15));
        foreach (phase_limits[p]) begin
            write_limit(phase_limits[p]);
            for (int n = 0; n < RANDOM_WORDS; n++) begin
                if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
                send_word(random_word());
            end
            burst_mode = 1'b0;
        end
    endtask

    // result side: random stalls, plus one long hold requested by the pressure test
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_active || stall_left > 0) begin
                i_ready = 1'b0;
                if (!hold_active) stall_left--;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    initial begin
        forever begin
            wait (hold_req);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_active = 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            stall_left = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending");
                fail_count++;
            end else begin
                want_word = pending_results.pop_front();
                if (o_data.ok !== want_word.ok) begin
                    $error("ok: expected %0d, got %0d", want_word.ok, o_data.ok);
                    fail_count++;
                end
                if (o_data.key_out !== want_word.key_out) begin
                    $error("key_out: expected %h, got %h", want_word.key_out, o_data.key_out);
                    fail_count++;
                end
                if (o_data.item_count !== want_word.item_count) begin
                    $error("item_count: expected %0d, got %0d",
                           want_word.item_count, o_data.item_count);
                    fail_count++;
                end
            end
        end
    end

    // no progress on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = bsrs_pkg::LIMIT_RESET;
        model_count = 0;
        model_limit = bsrs_pkg::LIMIT_RESET;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_basics();
        test_limit_edges();
        test_backpressure();
        test_random_mix();

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d words (insert %0d, erase %0d, contains %0d, get %0d), checked %0d",
                 words_sent, action_hits[bsrs_pkg::ACT_INSERT],
                 action_hits[bsrs_pkg::ACT_ERASE], action_hits[bsrs_pkg::ACT_CONTAINS],
                 action_hits[bsrs_pkg::ACT_GET], results_seen);
        $display("Limits 0, 1, 5, 16, 31 and a random one; one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
